// ===== hw/rtl/rotary_encoder_debounce_decoder_assert.svh =====
// Assertion macros for the rotary encoder block.
`ifndef ROTARY_ENCODER_DEBOUNCE_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_DEBOUNCE_DECODER_ASSERT_SVH

// Property checked on every edge once reset is released.
`define RTED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked on every edge, reset included.
`define RTED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rted_pkg.sv =====
package rted_pkg;

    localparam int AB_STABLE_SAMPLES_DEF = 8;
    localparam int SW_STABLE_SAMPLES_DEF = 7;

    localparam logic [3:0] DETENT_RESET = 4'd4;

    localparam int STATUS_W  = 6;
    localparam int COUNT_W   = 5;
    localparam int IN_BYTES  = 1;
    localparam int OUT_BYTES = 3;

    // status word bit positions
    localparam int ST_CW      = 0;
    localparam int ST_CCW     = 1;
    localparam int ST_DOWN    = 2;
    localparam int ST_UP      = 3;
    localparam int ST_PRESSED = 4;
    localparam int ST_DIRTY   = 5;

    typedef logic signed [1:0] t_step;

    // indexed by {last_b, last_a, b, a}
    localparam t_step QUAD_TABLE [0:15] = '{
        2'sd0,  2'sd1,  -2'sd1, 2'sd0,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        2'sd0,  -2'sd1, 2'sd1,  2'sd0
    };

    // per-tick events; bit order matches the status word
    typedef struct packed {
        logic pressed;
        logic up;
        logic down;
        logic ccw;
        logic cw;
    } t_events;

    typedef struct packed {
        logic ack_second;
        logic ack_first;
        logic sw_pin;
        logic b_pin;
        logic a_pin;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] second_status_out;
        logic [STATUS_W-1:0] first_status_out;
        t_events             ev;
    } t_out_word;

    // Sticky merge: opposite events cancel, a clean word tracks live events,
    // any change marks the word dirty.
    function automatic logic [STATUS_W-1:0] f_merge(logic [STATUS_W-1:0] s_in,
                                                    t_events ev);
        logic [STATUS_W-1:0] s;
        logic [4:0]          evb;
        s   = s_in;
        evb = ev;
        if (ev.cw) begin
            if (s[ST_CCW]) s[ST_CCW] = 1'b0;
            else           s[ST_CW]  = 1'b1;
        end
        if (ev.ccw) begin
            if (s[ST_CW]) s[ST_CW]  = 1'b0;
            else          s[ST_CCW] = 1'b1;
        end
        if (ev.down) begin
            if (s[ST_UP]) s[ST_UP]   = 1'b0;
            else          s[ST_DOWN] = 1'b1;
        end
        if (ev.up) begin
            if (s[ST_DOWN]) s[ST_DOWN] = 1'b0;
            else            s[ST_UP]   = 1'b1;
        end
        if (!s[ST_DIRTY]) begin
            s[ST_UP:ST_CW] = s[ST_UP:ST_CW] & evb[ST_UP:ST_CW];
            s[ST_PRESSED]  = ev.pressed;
        end
        if (s != s_in) s[ST_DIRTY] = 1'b1;
        return s;
    endfunction

endpackage

// ===== hw/rtl/rted_sw_debounce.sv =====
module rted_sw_debounce import rted_pkg::*; #(
    parameter int SW_STABLE_SAMPLES = SW_STABLE_SAMPLES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_sw_pin,
    output logic o_down,
    output logic o_up,
    output logic o_pressed
);

    logic [SW_STABLE_SAMPLES-1:0] r_hist, n_hist;
    logic                         r_pressed, n_pressed;

    always_comb begin
        n_hist    = {r_hist[SW_STABLE_SAMPLES-2:0], i_sw_pin};
        n_pressed = r_pressed;
        o_down    = 1'b0;
        o_up      = 1'b0;
        o_pressed = 1'b0;
        if (r_pressed) begin
            if (&n_hist) begin
                n_pressed = 1'b0;
                o_up      = 1'b1;
            end else begin
                o_pressed = 1'b1;
            end
        end else if (n_hist == '0) begin
            n_pressed = 1'b1;
            o_down    = 1'b1;
            o_pressed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= '1;
            r_pressed <= 1'b0;
        end else if (i_en) begin
            r_hist    <= n_hist;
            r_pressed <= n_pressed;
        end
    end

endmodule

// ===== hw/rtl/rted_quad_decode.sv =====
module rted_quad_decode import rted_pkg::*; #(
    parameter int AB_STABLE_SAMPLES = AB_STABLE_SAMPLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_a_pin,
    input  logic       i_b_pin,
    input  logic [3:0] i_steps_per_detent,
    output logic       o_cw,
    output logic       o_ccw
);

    logic [AB_STABLE_SAMPLES-1:0] r_a_hist, n_a_hist;
    logic [AB_STABLE_SAMPLES-1:0] r_b_hist, n_b_hist;
    logic [1:0]                   r_last_ab;
    logic signed [COUNT_W-1:0]    r_count, n_count;
    logic                         w_stable;
    t_step                        w_step;
    logic [3:0]                   w_lim;
    logic signed [COUNT_W:0]      w_sum;
    logic signed [COUNT_W:0]      w_pos_lim;
    logic signed [COUNT_W:0]      w_neg_lim;

    assign n_a_hist  = {r_a_hist[AB_STABLE_SAMPLES-2:0], i_a_pin};
    assign n_b_hist  = {r_b_hist[AB_STABLE_SAMPLES-2:0], i_b_pin};
    assign w_stable  = ((n_a_hist == '0) || (&n_a_hist)) &&
                       ((n_b_hist == '0) || (&n_b_hist));
    assign w_step    = QUAD_TABLE[{r_last_ab, i_b_pin, i_a_pin}];
    assign w_lim     = (i_steps_per_detent == 4'd0) ? 4'd1 : i_steps_per_detent;
    assign w_sum     = {r_count[COUNT_W-1], r_count}
                     + {{(COUNT_W-1){w_step[1]}}, w_step};
    assign w_pos_lim = $signed({2'b00, w_lim});
    assign w_neg_lim = -w_pos_lim;

    // ccw test first; the limits have opposite signs, so at most one of them can be hit
    always_comb begin
        o_cw    = 1'b0;
        o_ccw   = 1'b0;
        n_count = r_count;
        if (w_stable) begin
            n_count = w_sum[COUNT_W-1:0];
            if (w_sum <= w_neg_lim) begin
                o_ccw   = 1'b1;
                n_count = '0;
            end else if (w_sum >= w_pos_lim) begin
                o_cw    = 1'b1;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_hist  <= '0;
            r_b_hist  <= '0;
            r_last_ab <= 2'b00;
            r_count   <= '0;
        end else if (i_en) begin
            r_a_hist <= n_a_hist;
            r_b_hist <= n_b_hist;
            r_count  <= n_count;
            if (w_stable) r_last_ab <= {i_b_pin, i_a_pin};
        end
    end

endmodule

// ===== hw/rtl/rotary_encoder_debounce_decoder.sv =====
// Channel   | Dir | Handshake                     | Word
// ----------+-----+-------------------------------+------------------------------------
// in        | in  | s_axis_tvalid / s_axis_tready | a, b, sw, ack_first, ack_second
// out       | out | m_axis_tvalid / m_axis_tready | cw, ccw, down, up, held, status x2
// config    | in  | i_cfg_valid / o_cfg_ready     | steps_per_detent
//
// One word per cycle while the output is not stalled; an accepted word passes from the input register
// through the decode and merge logic into the output register.
// Synchronous active-low reset clears A/B histories, step count, status words, sets the
// switch history to all ones and steps_per_detent to 4. Config is always ready.
// A stalled output holds its word while the input register still accepts one more.
module rotary_encoder_debounce_decoder import rted_pkg::*; #(
    parameter int AB_STABLE_SAMPLES = AB_STABLE_SAMPLES_DEF,
    parameter int SW_STABLE_SAMPLES = SW_STABLE_SAMPLES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] a_pin, [1] b_pin, [2] sw_pin, [3] ack_first, [4] ack_second
    input  logic [IN_BYTES*8-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] rot_cw, [1] rot_ccw, [2] btn_down, [3] btn_up, [4] btn_held,
    // [10:5] first_status_out, [16:11] second_status_out
    output logic [OUT_BYTES*8-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [3:0]             i_cfg_data
);

    logic                r_in_valid;
    t_in_word            r_in_word;
    logic                r_out_valid;
    t_out_word           r_out_word;
    logic [3:0]          r_steps_per_detent;
    logic [STATUS_W-1:0] r_first_status, n_first_status;
    logic [STATUS_W-1:0] r_second_status, n_second_status;
    logic                w_adv;
    logic                w_fire;
    t_events             w_ev;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BYTES*8-$bits(t_out_word)){1'b0}}, r_out_word};

    rted_sw_debounce #(
        .SW_STABLE_SAMPLES(SW_STABLE_SAMPLES)
    ) u_sw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_fire),
        .i_sw_pin  (r_in_word.sw_pin),
        .o_down    (w_ev.down),
        .o_up      (w_ev.up),
        .o_pressed (w_ev.pressed)
    );

    rted_quad_decode #(
        .AB_STABLE_SAMPLES(AB_STABLE_SAMPLES)
    ) u_quad (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (w_fire),
        .i_a_pin            (r_in_word.a_pin),
        .i_b_pin            (r_in_word.b_pin),
        .i_steps_per_detent (r_steps_per_detent),
        .o_cw               (w_ev.cw),
        .o_ccw              (w_ev.ccw)
    );

    // ack drops the dirty bit ahead of the merge
    always_comb begin
        n_first_status  = r_first_status;
        n_second_status = r_second_status;
        if (r_in_word.ack_first)  n_first_status[ST_DIRTY]  = 1'b0;
        if (r_in_word.ack_second) n_second_status[ST_DIRTY] = 1'b0;
        n_first_status  = f_merge(n_first_status, w_ev);
        n_second_status = f_merge(n_second_status, w_ev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_steps_per_detent <= DETENT_RESET;
            r_first_status     <= '0;
            r_second_status    <= '0;
        end else begin
            if (s_axis_tready) r_in_valid  <= s_axis_tvalid;
            if (w_adv)         r_out_valid <= r_in_valid;
            if (i_cfg_valid)   r_steps_per_detent <= i_cfg_data;
            if (w_fire) begin
                r_first_status  <= n_first_status;
                r_second_status <= n_second_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata[$bits(t_in_word)-1:0];
        end
        if (w_fire) begin
            r_out_word.ev                <= w_ev;
            r_out_word.first_status_out  <= n_first_status;
            r_out_word.second_status_out <= n_second_status;
        end
    end

`include "rotary_encoder_debounce_decoder_assert.svh"

    `RTED_ASSERT(a_no_cw_and_ccw, !(w_fire && w_ev.cw && w_ev.ccw), "cw and ccw in one tick")
    `RTED_ASSERT(a_down_is_held, (w_fire && w_ev.down) |-> w_ev.pressed, "down without held")
    `RTED_ASSERT(a_status_dir, !(r_first_status[ST_CW] && r_first_status[ST_CCW]), "cw/ccw both set")
    `RTED_ASSERT(a_out_from_in, $rose(r_out_valid) |-> $past(r_in_valid), "output without input")

endmodule
